// File: rtl/tta_pkg.sv
// Shared constants for the transpose address generator.
// No dependencies; imported by tta_divider and tensor_transpose_address_generator.
`timescale 1ns / 1ps
`default_nettype none

package tta_pkg;

  localparam int LANE_W         = 16;
  localparam int LANES          = 4;
  localparam int NUM_W          = 20;
  localparam int ELEM_W         = 13;
  localparam int ADDR_W         = 32;
  localparam int VOL_W          = 14;
  localparam int CNT_W          = 7;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 64;
  localparam int MAX_DIMS_DEF   = 4;
  localparam int TILE_DEPTH_DEF = 8192;

  localparam logic [CFG_DATA_W-1:0] SHAPES_RESET = 64'h0001_0001_0001_0001;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIM_COUNTS   = 3'd0,
    CFG_TILE_VOLUME  = 3'd1,
    CFG_INNER_SHAPES = 3'd2,
    CFG_OUTER_SHAPES = 3'd3,
    CFG_LOCAL_STR    = 3'd4,
    CFG_GLOBAL_STR   = 3'd5,
    CFG_OUTER_STR    = 3'd6,
    CFG_UNUSED       = 3'd7
  } cfg_idx_e;

endpackage

`default_nettype wire

// File: rtl/tta_divider.sv
// Pipelined restoring divider pair: two NUM_W-bit numerators by 16-bit divisors,
// one quotient bit per stage, with a side bundle carried along. Uses tta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tta_divider
  import tta_pkg::*;
#(
  parameter int PW = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [NUM_W-1:0]  num_a_i,
  input  wire logic [NUM_W-1:0]  num_b_i,
  input  wire logic [LANE_W-1:0] den_a_i,
  input  wire logic [LANE_W-1:0] den_b_i,
  input  wire logic [PW-1:0]     side_i,
  output logic                   valid_o,
  output logic [NUM_W-1:0]       quo_a_o,
  output logic [NUM_W-1:0]       quo_b_o,
  output logic [LANE_W-1:0]      rem_a_o,
  output logic [LANE_W-1:0]      rem_b_o,
  output logic [PW-1:0]          side_o
);

  logic              v_q  [NUM_W];
  logic [NUM_W-1:0]  xa_q [NUM_W];
  logic [NUM_W-1:0]  xb_q [NUM_W];
  logic [LANE_W-1:0] ra_q [NUM_W];
  logic [LANE_W-1:0] rb_q [NUM_W];
  logic [LANE_W-1:0] da_q [NUM_W];
  logic [LANE_W-1:0] db_q [NUM_W];
  logic [PW-1:0]     sd_q [NUM_W];

  logic [NUM_W-1:0]  xa_d [NUM_W];
  logic [NUM_W-1:0]  xb_d [NUM_W];
  logic [LANE_W-1:0] ra_d [NUM_W];
  logic [LANE_W-1:0] rb_d [NUM_W];

  function automatic logic [LANE_W:0] div_step(input logic [LANE_W-1:0] rem,
                                               input logic              nbit,
                                               input logic [LANE_W-1:0] den);
    logic [LANE_W:0] t;
    logic            ge;
    t  = {rem, nbit};
    ge = (t >= {1'b0, den});
    if (ge) begin
      t = t - {1'b0, den};
    end
    return {ge, t[LANE_W-1:0]};
  endfunction

  always_comb begin
    logic [LANE_W:0]   sa, sb;
    logic [NUM_W-1:0]  xa, xb;
    logic [LANE_W-1:0] ra, rb, da, db;
    for (int s = 0; s < NUM_W; s++) begin
      if (s == 0) begin
        xa = num_a_i; xb = num_b_i; ra = '0; rb = '0; da = den_a_i; db = den_b_i;
      end else begin
        xa = xa_q[s-1]; xb = xb_q[s-1]; ra = ra_q[s-1]; rb = rb_q[s-1];
        da = da_q[s-1]; db = db_q[s-1];
      end
      sa = div_step(ra, xa[NUM_W-1], da);
      sb = div_step(rb, xb[NUM_W-1], db);
      xa_d[s] = {xa[NUM_W-2:0], sa[LANE_W]};
      xb_d[s] = {xb[NUM_W-2:0], sb[LANE_W]};
      ra_d[s] = sa[LANE_W-1:0];
      rb_d[s] = sb[LANE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_W; s++) begin
        v_q[s] <= 1'b0;
      end
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int s = 1; s < NUM_W; s++) begin
        v_q[s] <= v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NUM_W; s++) begin
        xa_q[s] <= xa_d[s];
        xb_q[s] <= xb_d[s];
        ra_q[s] <= ra_d[s];
        rb_q[s] <= rb_d[s];
      end
      da_q[0] <= den_a_i;
      db_q[0] <= den_b_i;
      sd_q[0] <= side_i;
      for (int s = 1; s < NUM_W; s++) begin
        da_q[s] <= da_q[s-1];
        db_q[s] <= db_q[s-1];
        sd_q[s] <= sd_q[s-1];
      end
    end
  end

  assign valid_o = v_q[NUM_W-1];
  assign quo_a_o = xa_q[NUM_W-1];
  assign quo_b_o = xb_q[NUM_W-1];
  assign rem_a_o = ra_q[NUM_W-1];
  assign rem_b_o = rb_q[NUM_W-1];
  assign side_o  = sd_q[NUM_W-1];

endmodule

`default_nettype wire

// File: rtl/tensor_transpose_address_generator.sv
// Transpose address generator top level: config registers, divider chain, multiply/sum stages.
// Depends on tta_pkg and tta_divider.
//
//   channel | dir | handshake                   | payload
//   in      | in  | in_valid_i / in_stall_o     | tile_number_i, element_index_i
//   out     | out | out_valid_o / out_stall_i   | out_address_o, in_address_o, bad_index_o
//   cfg     | in  | cfg_valid_i / cfg_ready_o   | cfg_index_i, cfg_data_i
//
// One request per cycle while in_stall_o is low; the divider stages are bit-serial
// (one quotient bit per stage per dimension).
// Reset clears valid bits and loads the register reset values.
// A stalled output freezes the pipeline unless its last stage holds a bubble.
`timescale 1ns / 1ps
`default_nettype none

module tensor_transpose_address_generator
  import tta_pkg::*;
#(
  parameter int MAX_DIMS   = MAX_DIMS_DEF,
  parameter int TILE_DEPTH = TILE_DEPTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [NUM_W-1:0]      tile_number_i,
  input  wire logic [ELEM_W-1:0]     element_index_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [ADDR_W-1:0]          out_address_o,
  output logic [ADDR_W-1:0]          in_address_o,
  output logic                       bad_index_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int NL   = (MAX_DIMS < LANES) ? MAX_DIMS : LANES;
  localparam int BASE = NUM_W + ELEM_W;
  localparam int PW   = BASE + 2 * LANE_W * NL;

  logic [CNT_W-1:0]      dim_counts_q;
  logic [VOL_W-1:0]      tile_volume_q;
  logic [CFG_DATA_W-1:0] inner_shapes_q, outer_shapes_q;
  logic [CFG_DATA_W-1:0] local_str_q, global_str_q, outer_str_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_counts_q   <= '0;
      tile_volume_q  <= VOL_W'(1);
      inner_shapes_q <= SHAPES_RESET;
      outer_shapes_q <= SHAPES_RESET;
      local_str_q    <= '0;
      global_str_q   <= '0;
      outer_str_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DIM_COUNTS:   dim_counts_q   <= cfg_data_i[CNT_W-1:0];
        CFG_TILE_VOLUME:  tile_volume_q  <= cfg_data_i[VOL_W-1:0];
        CFG_INNER_SHAPES: inner_shapes_q <= cfg_data_i;
        CFG_OUTER_SHAPES: outer_shapes_q <= cfg_data_i;
        CFG_LOCAL_STR:    local_str_q    <= cfg_data_i;
        CFG_GLOBAL_STR:   global_str_q   <= cfg_data_i;
        CFG_OUTER_STR:    outer_str_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // static config decode
  logic [3:0]        n_in, n_out;
  logic [LANE_W-1:0] den_o [NL];
  logic [LANE_W-1:0] den_i [NL];
  logic [VOL_W-1:0]  vol;

  always_comb begin
    logic [LANE_W-1:0] so, si;
    n_in  = (32'(dim_counts_q[3:0]) > NL) ? 4'(NL) : dim_counts_q[3:0];
    n_out = (32'(dim_counts_q[6:4]) > NL) ? 4'(NL) : {1'b0, dim_counts_q[6:4]};
    for (int i = 0; i < NL; i++) begin
      so = outer_shapes_q[LANE_W*i +: LANE_W];
      si = inner_shapes_q[LANE_W*i +: LANE_W];
      den_o[i] = (32'(n_out) > i && so != '0) ? so : LANE_W'(1);
      den_i[i] = (32'(n_in) > i && si != '0) ? si : LANE_W'(1);
    end
    vol = (32'(tile_volume_q) > TILE_DEPTH) ? VOL_W'(TILE_DEPTH) : tile_volume_q;
  end

  // pipeline control
  logic en;
  logic p_valid_q;
  logic out_valid_q;
  logic out_load;

  assign out_load   = !(out_valid_q && out_stall_i);
  assign en         = out_load || !p_valid_q;
  assign in_stall_o = !en;

  // divider chain
  logic              dv    [NL+1];
  logic [NUM_W-1:0]  rest_o[NL+1];
  logic [NUM_W-1:0]  rest_i[NL+1];
  logic [PW-1:0]     side  [NL+1];
  logic [PW-1:0]     side_o[NL];
  logic [LANE_W-1:0] rem_o [NL];
  logic [LANE_W-1:0] rem_i [NL];

  assign dv[0]     = in_valid_i;
  assign rest_o[0] = tile_number_i;
  assign rest_i[0] = NUM_W'(element_index_i);
  assign side[0]   = PW'({tile_number_i, element_index_i});

  for (genvar g = 0; g < NL; g++) begin : g_dim
    tta_divider #(.PW(PW)) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[g]),
      .num_a_i (rest_o[g]),
      .num_b_i (rest_i[g]),
      .den_a_i (den_o[g]),
      .den_b_i (den_i[g]),
      .side_i  (side[g]),
      .valid_o (dv[g+1]),
      .quo_a_o (rest_o[g+1]),
      .quo_b_o (rest_i[g+1]),
      .rem_a_o (rem_o[g]),
      .rem_b_o (rem_i[g]),
      .side_o  (side_o[g])
    );

    always_comb begin
      side[g+1] = side_o[g];
      side[g+1][BASE + 2*LANE_W*g +: 2*LANE_W] = {rem_i[g], rem_o[g]};
    end
  end

  // product stage
  logic [ADDR_W-1:0] po_q [NL];
  logic [ADDR_W-1:0] pg_q [NL];
  logic [ADDR_W-1:0] pl_q [NL];
  logic [ADDR_W-1:0] tv_q;
  logic              bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (en) begin
      p_valid_q <= dv[NL];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NL; i++) begin
        po_q[i] <= ADDR_W'(side[NL][BASE + 2*LANE_W*i +: LANE_W]) *
                   ADDR_W'(outer_str_q[LANE_W*i +: LANE_W]);
        pg_q[i] <= ADDR_W'(side[NL][BASE + 2*LANE_W*i + LANE_W +: LANE_W]) *
                   ADDR_W'(global_str_q[LANE_W*i +: LANE_W]);
        pl_q[i] <= ADDR_W'(side[NL][BASE + 2*LANE_W*i + LANE_W +: LANE_W]) *
                   ADDR_W'(local_str_q[LANE_W*i +: LANE_W]);
      end
      tv_q  <= ADDR_W'(side[NL][BASE-1:ELEM_W]) * ADDR_W'(vol);
      bad_q <= (VOL_W'(side[NL][ELEM_W-1:0]) >= vol);
    end
  end

  // sum stage / output register
  logic [ADDR_W-1:0] out_addr_q, in_addr_q;
  logic              out_bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [ADDR_W-1:0] a, l;
    a = '0;
    l = '0;
    for (int i = 0; i < NL; i++) begin
      a = a + po_q[i] + pg_q[i];
      l = l + pl_q[i];
    end
    if (out_load) begin
      out_addr_q <= a;
      in_addr_q  <= tv_q + l;
      out_bad_q  <= bad_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_address_o = out_addr_q;
  assign in_address_o  = in_addr_q;
  assign bad_index_o   = out_bad_q;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && p_valid_q))
    else $error("input stalled without a blocked result");

  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(p_valid_q))
    else $error("result appeared without a request in the last stage");

  a_pipe_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_valid_q && !out_stall_i) |=> out_valid_o)
    else $error("last stage request not moved to output");

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Testbench for tensor_transpose_address_generator: random and directed address requests
// checked against an in-bench mixed-radix predictor. Depends on tta_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
  import tta_pkg::*;

  localparam int LATENCY = 20 * 4 + 2;
  localparam int LIMIT   = 2000000;

  typedef struct packed {
    logic [ADDR_W-1:0] out_addr;
    logic [ADDR_W-1:0] in_addr;
    logic              bad;
  } addr_t;

  class addr_scoreboard;
    logic [6:0]  dims;
    logic [13:0] vol_reg;
    logic [63:0] in_shp, out_shp, loc_str, glb_str, out_str;
    addr_t       pending[$];
    bit          failed;

    function void reset_regs();
      dims = '0; vol_reg = 14'd1; in_shp = SHAPES_RESET; out_shp = SHAPES_RESET;
      loc_str = '0; glb_str = '0; out_str = '0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [63:0] val);
      case (idx)
        CFG_DIM_COUNTS:   dims = val[6:0];
        CFG_TILE_VOLUME:  vol_reg = val[13:0];
        CFG_INNER_SHAPES: in_shp = val;
        CFG_OUTER_SHAPES: out_shp = val;
        CFG_LOCAL_STR:    loc_str = val;
        CFG_GLOBAL_STR:   glb_str = val;
        CFG_OUTER_STR:    out_str = val;
        default: ;
      endcase
    endfunction

    function void note_request(logic [NUM_W-1:0] tile, logic [ELEM_W-1:0] elem);
      int unsigned n_in, n_out, vol, rest, s, q, d;
      logic [31:0] addr, loc;
      addr_t r;
      n_in = dims[3:0]; if (n_in > 4) n_in = 4;
      n_out = dims[6:4]; if (n_out > 4) n_out = 4;
      vol = vol_reg; if (vol > 8192) vol = 8192;
      addr = 0; loc = 0; rest = tile;
      for (int i = 0; i < n_out; i++) begin
        s = out_shp[16*i +: 16]; if (s == 0) s = 1;
        q = rest / s; d = rest - q * s;
        addr += out_str[16*i +: 16] * d; rest = q;
      end
      rest = elem;
      for (int i = 0; i < n_in; i++) begin
        s = in_shp[16*i +: 16]; if (s == 0) s = 1;
        q = rest / s; d = rest - q * s;
        addr += glb_str[16*i +: 16] * d;
        loc += loc_str[16*i +: 16] * d; rest = q;
      end
      r.out_addr = addr;
      r.in_addr = tile * vol + loc;
      r.bad = (elem >= vol);
      pending.push_back(r);
    endfunction

    function void check_result(addr_t act);
      addr_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, act);
        failed = 1;
        return;
      end
      e = pending.pop_front();
      if (e.out_addr !== act.out_addr) begin
        $display("%0t: out_address exp %h act %h", $time, e.out_addr, act.out_addr);
        failed = 1;
      end
      if (e.in_addr !== act.in_addr) begin
        $display("%0t: in_address exp %h act %h", $time, e.in_addr, act.in_addr);
        failed = 1;
      end
      if (e.bad !== act.bad) begin
        $display("%0t: bad_index exp %b act %b", $time, e.bad, act.bad);
        failed = 1;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, out_stall_i = 0, cfg_valid_i = 0;
  logic [NUM_W-1:0] tile_number_i = '0;
  logic [ELEM_W-1:0] element_index_i = '0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_stall_o, out_valid_o, cfg_ready_o, bad_index_o;
  logic [ADDR_W-1:0] out_address_o, in_address_o;

  addr_scoreboard sb = new();
  int cycles = 0;
  bit quiet = 0;
  bit hold_off = 0;

  always #5 clk_i = ~clk_i;

  tensor_transpose_address_generator u_top (.*);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[tensor_transpose_address_generator] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result('{out_address_o, in_address_o, bad_index_o});
    out_stall_i <= hold_off || (!quiet && $urandom_range(99) < 10);
  end

  // valid stays high after the write; the next send or drain drops it
  task automatic write_cfg(cfg_idx_e idx, logic [63:0] val);
    cfg_valid_i <= 1; cfg_index_i <= idx; cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
  endtask

  task automatic send(logic [NUM_W-1:0] tile, logic [ELEM_W-1:0] elem);
    cfg_valid_i <= 0;
    while (!quiet && $urandom_range(99) < 10) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1; tile_number_i <= tile; element_index_i <= elem;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(tile, elem);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    cfg_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_lanes(int unsigned hi);
    logic [63:0] v;
    for (int i = 0; i < 4; i++) v[16*i +: 16] = 16'($urandom_range(hi));
    return v;
  endfunction

  task automatic rand_cfg(bit extreme);
    write_cfg(CFG_DIM_COUNTS, 64'({3'($urandom_range(7)), 4'($urandom_range(15))}));
    write_cfg(CFG_TILE_VOLUME, extreme ? 64'h3FFF : 64'($urandom_range(16383)));
    write_cfg(CFG_INNER_SHAPES, extreme ? 64'hFFFF_0000_FFFF_0000 : rand_lanes(12));
    write_cfg(CFG_OUTER_SHAPES, extreme ? 64'hFFFF_FFFF_0000_FFFF : rand_lanes(20));
    write_cfg(CFG_LOCAL_STR, extreme ? '1 : {$urandom, $urandom});
    write_cfg(CFG_GLOBAL_STR, extreme ? '1 : {$urandom, $urandom});
    write_cfg(CFG_OUTER_STR, extreme ? '1 : {$urandom, $urandom});
    write_cfg(CFG_UNUSED, {$urandom, $urandom});
  endtask

  initial begin
    sb.reset_regs();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send('0, '0);
    send('1, '1);
    send(20'd5, 13'd1);
    drain();
    rand_cfg(1);
    send('1, '1);
    send(20'hABCDE, 13'h1555);
    send('0, 13'd8191);
    drain();
    write_cfg(CFG_DIM_COUNTS, 64'h44);
    write_cfg(CFG_TILE_VOLUME, 64'd0);
    write_cfg(CFG_INNER_SHAPES, 64'h0004_0003_0002_0001);
    write_cfg(CFG_OUTER_SHAPES, 64'h0005_0000_0003_0002);
    write_cfg(CFG_LOCAL_STR, 64'h0018_0006_0002_0001);
    write_cfg(CFG_GLOBAL_STR, 64'h1000_0100_0010_0001);
    write_cfg(CFG_OUTER_STR, 64'hFFFF_8000_0101_0007);
    send(20'd0, 13'd0);
    send(20'd1234, 13'd23);
    send('1, '1);
    drain();
    write_cfg(CFG_TILE_VOLUME, 64'd8192);
    send(20'd7, 13'd8191);
    send(20'd7, 13'd100);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      rand_cfg(0);
      quiet = (ph == 2);
      if (ph == 3) fork
        begin
          hold_off = 1;
          repeat (300) @(posedge clk_i);
          hold_off = 0;
        end
      join_none
      for (int k = 0; k < ((ph == 3) ? 120 : 66); k++)
        send(NUM_W'($urandom), (sb.vol_reg != 0 && $urandom_range(3) != 0) ?
             ELEM_W'($urandom_range(sb.vol_reg > 8191 ? 8191 : sb.vol_reg - 1)) :
             ELEM_W'($urandom));
      drain();
    end
    if (!sb.failed && sb.pending.size() == 0) begin
      $display("[tensor_transpose_address_generator] OK");
    end else begin
      $display("[tensor_transpose_address_generator] ERROR");
    end
    $finish;
  end

endmodule
